// File: src/sha1_pkg.sv
// Shared constants, types and helpers for the SHA-1 hasher.
package sha1_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 5;
  localparam int unsigned BlockBits = 512;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned FillW     = 6;
  localparam int unsigned LenW      = 61;
  localparam int unsigned IdxW      = 3;

  typedef logic [WordW-1:0] word_t;

  localparam word_t HInit [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [RoundW-1:0] Rnd20     = 7'd20;
  localparam logic [RoundW-1:0] Rnd40     = 7'd40;
  localparam logic [RoundW-1:0] Rnd60     = 7'd60;
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);

  localparam logic [7:0]       PadByte  = 8'h80;
  localparam logic [7:0]       ZeroByte = 8'h00;
  localparam logic [FillW-1:0] LenPos   = 6'd56;
  localparam logic [FillW-1:0] FillLast = 6'd63;
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(NumWords - 1);

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic start;   // load working words from the chaining words
    logic step;    // run one round
    logic fold;    // add working words into the chaining words
    logic reinit;  // restore the initial chaining words
  } core_ctrl_t;

  // Control from the sequencer to the block buffer
  typedef struct packed {
    logic push;    // shift in one byte
    logic shift;   // advance the schedule by one word
  } sched_ctrl_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

endpackage

// File: src/sha1_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: src/sha1_sched.sv
// Block buffer: gathers bytes big-endian and produces the message schedule.
module sha1_sched
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  input  logic [7:0]  byte_i,
  output word_t       w_o
);

  logic [BlockBits-1:0] win_q, win_d;
  word_t                w0, w2, w8, w13, next_w;

  // Window word i sits at bits [BlockBits-1-32*i -: 32], oldest first
  assign w0  = win_q[BlockBits-1            -: WordW];
  assign w2  = win_q[BlockBits-1-WordW*2    -: WordW];
  assign w8  = win_q[BlockBits-1-WordW*8    -: WordW];
  assign w13 = win_q[BlockBits-1-WordW*13   -: WordW];

  assign next_w = rotl(w13 ^ w8 ^ w2 ^ w0, 1);
  assign w_o    = w0;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.shift) begin
      win_d = {win_q[BlockBits-WordW-1:0], next_w};
    end else if (ctrl_i.push) begin
      win_d = {win_q[BlockBits-9:0], byte_i};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// File: src/sha1_core.sv
// Round unit: chaining words, working words and the shared round datapath.
module sha1_core
  import sha1_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  core_ctrl_t      ctrl_i,
  input  word_t           w_i,
  input  logic [IdxW-1:0] sel_i,
  output logic            last_round_o,
  output word_t           digest_o
);

  word_t             h_q [NumWords];
  word_t             a_q, b_q, c_q, d_q, e_q;
  logic [RoundW-1:0] rnd_q;
  word_t             f, k, tmp;

  always_comb begin
    if (rnd_q < Rnd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < Rnd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < Rnd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
  end

  assign tmp          = rotl(a_q, 5) + f + e_q + k + w_i;
  assign last_round_o = (rnd_q == LastRound);

  always_comb begin
    case (sel_i)
      3'd0:    digest_o = h_q[0];
      3'd1:    digest_o = h_q[1];
      3'd2:    digest_o = h_q[2];
      3'd3:    digest_o = h_q[3];
      default: digest_o = h_q[4];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= HInit;
      rnd_q <= '0;
    end else begin
      if (ctrl_i.reinit) begin
        h_q <= HInit;
      end else if (ctrl_i.fold) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (ctrl_i.start) begin
        rnd_q <= '0;
      end else if (ctrl_i.step) begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (ctrl_i.step) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

// File: src/sha1_message_hasher.sv
// SHA-1 hasher top level: byte intake, padding sequencer and digest output.
//
//   channel  dir  payload                               transfer when
//   in_i     in   data_byte, has_byte, end_of_message   valid && ready
//   out_o    out  digest_word, word_index, last_word    valid && ready
//
// Bytes are accepted while in StIdle. The 64th byte of a block starts
// compression: the single round unit runs 80 rounds, one per cycle, then
// adds into the chaining words, and in_i.ready stays low meanwhile.
// Closing a message writes the padding one byte per cycle outside compression
// (up to 72 across two blocks), runs one or two compressions and then holds
// out_o.valid for five transfers.
// Reset is asynchronous and restores the initial chaining words at once.
module sha1_message_hasher
  import sha1_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StFold  = 5'b00100,
    StPad   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              pad_q, pad_d;        // message closed, padding under way
  logic              sent80_q, sent80_d;  // marker byte written
  logic              lenok_q, lenok_d;    // length may go into this block
  logic              lastblk_q, lastblk_d;

  core_ctrl_t        core_ctrl;
  sched_ctrl_t       sched_ctrl;
  logic [7:0]        push_byte;
  logic [63:0]       len_bits;
  logic [7:0]        len_byte;
  logic              last_round;
  logic              in_xfer, out_xfer;
  word_t             w;
  word_t             digest;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  assign len_bits = {len_q, 3'b000};
  // Length bytes go out most significant first at positions 56 to 63
  assign len_byte = 8'(len_bits >> {~fill_q[2:0], 3'b000});

  assign in_i.ready         = (state_q == StIdle);
  assign out_o.valid        = (state_q == StOut);
  assign out_o.digest_word  = digest;
  assign out_o.word_index   = idx_q;
  assign out_o.last_word    = (idx_q == LastIdx);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    len_d      = len_q;
    idx_d      = idx_q;
    pad_d      = pad_q;
    sent80_d   = sent80_q;
    lenok_d    = lenok_q;
    lastblk_d  = lastblk_q;
    core_ctrl  = '0;
    sched_ctrl = '0;
    push_byte  = in_i.data_byte;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.has_byte) begin
            sched_ctrl.push = 1'b1;
            fill_d          = fill_q + 1'b1;
            len_d           = len_q + 1'b1;
          end
          if (in_i.end_of_message) begin
            pad_d = 1'b1;
          end
          if (in_i.has_byte && (fill_q == FillLast)) begin
            core_ctrl.start = 1'b1;
            state_d         = StRound;
          end else if (in_i.end_of_message) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        sched_ctrl.push = 1'b1;
        fill_d          = fill_q + 1'b1;
        if (!sent80_q) begin
          push_byte = PadByte;
          sent80_d  = 1'b1;
          lenok_d   = (fill_q < LenPos);
        end else if (lenok_q && (fill_q >= LenPos)) begin
          push_byte = len_byte;
        end else begin
          push_byte = ZeroByte;
        end
        if (fill_q == FillLast) begin
          lastblk_d       = lenok_d;
          core_ctrl.start = 1'b1;
          state_d         = StRound;
        end
      end
      StRound: begin
        core_ctrl.step   = 1'b1;
        sched_ctrl.shift = 1'b1;
        if (last_round) begin
          state_d = StFold;
        end
      end
      StFold: begin
        core_ctrl.fold = 1'b1;
        if (lastblk_q) begin
          idx_d   = '0;
          state_d = StOut;
        end else if (pad_q) begin
          // A block that held the marker leaves room for the length in the next
          lenok_d = lenok_q | sent80_q;
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_xfer) begin
          if (idx_q == LastIdx) begin
            core_ctrl.reinit = 1'b1;
            len_d            = '0;
            pad_d            = 1'b0;
            sent80_d         = 1'b0;
            lenok_d          = 1'b0;
            lastblk_d        = 1'b0;
            state_d          = StIdle;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      len_q     <= '0;
      idx_q     <= '0;
      pad_q     <= 1'b0;
      sent80_q  <= 1'b0;
      lenok_q   <= 1'b0;
      lastblk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      pad_q     <= pad_d;
      sent80_q  <= sent80_d;
      lenok_q   <= lenok_d;
      lastblk_q <= lastblk_d;
    end
  end

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .byte_i (push_byte),
    .w_o    (w)
  );

  sha1_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (core_ctrl),
    .w_i          (w),
    .sel_i        (idx_q),
    .last_round_o (last_round),
    .digest_o     (digest)
  );

endmodule

// File: tb/tb_sha1_message_hasher.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-1 message hasher: byte streams in, digest words checked.
module tb_sha1_message_hasher;
  import sha1_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned NoisePct     = 5;
  localparam int unsigned ShortMax     = 12;
  localparam int unsigned PhaseItems   = 6;
  localparam int unsigned TwoBlockLen  = 56;
  localparam int unsigned FullBlockLen = 64;

  typedef struct packed {
    word_t           word;
    logic [IdxW-1:0] idx;
    logic            is_last;
  } digest_beat_t;

  logic clk_i;
  logic rst_ni;

  sha1_in_if  in_if ();
  sha1_out_if out_if ();

  sha1_message_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Own copy of the hashing state
  word_t            hash_chain [NumWords];
  logic [7:0]       blk_buf [64];
  int unsigned      blk_fill;
  logic [LenW-1:0]  msg_len;
  digest_beat_t     digest_q [$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned stall_cycles = 0;
  int unsigned err_count    = 0;
  int unsigned item_count   = 0;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic void hash_restart();
    for (int i = 0; i < NumWords; i++) hash_chain[i] = HInit[i];
    blk_fill = 0;
    msg_len  = '0;
  endfunction

  function automatic void hash_compress();
    word_t sched [NumRounds];
    word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < NumRounds; i++) begin
      t = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
      sched[i] = {t[30:0], t[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int i = 0; i < NumRounds; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + sched[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void hash_absorb(logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill++;
    msg_len++;
    if (blk_fill == 64) begin
      hash_compress();
      blk_fill = 0;
    end
  endfunction

  // Pad, append the bit length, and queue the five digest words
  function automatic void hash_close();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    blk_buf[blk_fill] = PadByte;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_buf[blk_fill] = ZeroByte;
        blk_fill++;
      end
      hash_compress();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_buf[blk_fill] = ZeroByte;
      blk_fill++;
    end
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[8*(7-i) +: 8];
    hash_compress();
    for (int i = 0; i < NumWords; i++) begin
      beat = '{word: hash_chain[i], idx: IdxW'(i), is_last: (i == NumWords - 1)};
      digest_q = {digest_q, beat};
    end
    hash_restart();
  endfunction

  // Start at a falling edge, hold the item until its transfer, end at a falling edge
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.has_byte       <= hb;
    in_if.end_of_message <= eom;
    do @(posedge clk_i); while (!in_if.ready);
    item_count++;
    if (hb) hash_absorb(b);
    if (eom) hash_close();
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input bit close_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < NoisePct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_special_items();
    // Ignored item, then a close with nothing received: empty message
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // Two closes in a row
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);
    // Byte and close in one item
    send_item(8'hFF, 1'b1, 1'b1);
    // Byte, ignored item, then a bare close
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_abc_message();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // Close past the length slot: marker and length land in separate blocks
  task automatic test_two_block_padding();
    send_message(TwoBlockLen, 1'b1);
  endtask

  // The byte that fills the block also closes the message
  task automatic test_full_block_close();
    send_message(FullBlockLen, 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned first_items;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    first_items   = item_count;
    while (item_count - first_items < PhaseItems) begin
      send_message($urandom_range(ShortMax), 1'($urandom_range(1)));
    end
  endtask

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    digest_beat_t want;
    digest_beat_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{word: out_if.digest_word, idx: out_if.word_index, is_last: out_if.last_word};
      if (digest_q.size() == 0) begin
        if (err_count < MaxReports)
          $display("%0t: unexpected digest word %h idx %0d last %b",
                   $realtime, got.word, got.idx, got.is_last);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          if (err_count < MaxReports)
            $display("%0t: digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     $realtime, want.word, want.idx, want.is_last,
                     got.word, got.idx, got.is_last);
          err_count++;
        end
      end
    end
  end

  // Drop the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = 8'h00;
    in_if.has_byte       = 1'b0;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;
    src_idle_pct         = 32;
    sink_idle_pct        = 55;
    hash_restart();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_special_items();
    test_abc_message();
    test_two_block_padding();
    test_random_messages(55, 32);
    test_full_block_close();
    test_random_messages(0, 0);
    in_if.valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && digest_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/sha1_pkg.sv
src/sha1_if.sv
src/sha1_sched.sv
src/sha1_core.sv
src/sha1_message_hasher.sv
tb/tb_sha1_message_hasher.sv
